/* sv/mfe_pkg.sv */
// shared types, constants and helpers of the multi-fractal escape-time engine
// used by mfe_mul, mfe_core and the top level
package mfe_pkg;

	localparam int FRAC_BITS = 32;
	localparam int VAL_W     = FRAC_BITS + 8;
	localparam int HALF_W    = VAL_W / 2;
	localparam int PROD_W    = 2 * VAL_W;
	localparam int SH_W      = PROD_W - FRAC_BITS;
	localparam int SUM_W     = VAL_W + 6;
	localparam int CNT_W     = 16;
	localparam int PT_W      = 32;
	localparam int FIX_SHIFT = FRAC_BITS - 28;
	localparam int MODE_W    = 3;
	localparam int RAD_W     = 3;
	localparam int IDX_W     = 3;

	localparam logic [MODE_W-1:0] MODE_MANDEL  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_JULIA   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SHIP    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_MANOWAR = 3'd3;
	localparam logic [MODE_W-1:0] MODE_PHOENIX = 3'd4;

	localparam logic [IDX_W-1:0] REG_MODE   = 3'd0;
	localparam logic [IDX_W-1:0] REG_LIMIT  = 3'd1;
	localparam logic [IDX_W-1:0] REG_RADIUS = 3'd2;
	localparam logic [IDX_W-1:0] REG_CRE    = 3'd3;
	localparam logic [IDX_W-1:0] REG_CIM    = 3'd4;

	localparam logic [63:0] PHX_RAW =
		(64'd56667 * (64'd1 << FRAC_BITS) + 64'd50000) / 64'd100000;
	localparam logic signed [VAL_W-1:0] PHOENIX_P = VAL_W'(PHX_RAW);

	typedef struct packed {
		logic [MODE_W-1:0]       mode;
		logic [CNT_W-1:0]        limit;
		logic [RAD_W-1:0]        radius;
		logic signed [PT_W-1:0]  cre;
		logic signed [PT_W-1:0]  cim;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             escaped;
		logic [VAL_W-1:0] mag;
	} res_t;

	typedef struct packed {
		logic en;
		logic hi;
	} mul_ctl_t;

	// Q4.28 point to internal fixed point
	function automatic logic signed [VAL_W-1:0] to_fix(input logic signed [PT_W-1:0] q);
		logic signed [VAL_W-1:0] e;
		e = VAL_W'(q);
		return e <<< FIX_SHIFT;
	endfunction

	// product >> FRAC_BITS, capped at all ones
	function automatic logic [VAL_W-1:0] sq_cap(input logic [PROD_W-1:0] p);
		logic [SH_W-1:0] s;
		s = p[PROD_W-1:FRAC_BITS];
		if (|s[SH_W-1:VAL_W])
			return '1;
		return s[VAL_W-1:0];
	endfunction

	// product >> FRAC_BITS, capped at 2^VAL_W
	function automatic logic [VAL_W:0] cross_cap(input logic [PROD_W-1:0] p);
		logic [SH_W-1:0] s;
		s = p[PROD_W-1:FRAC_BITS];
		if ((|s[SH_W-1:VAL_W+1]) || (s[VAL_W] && (|s[VAL_W-1:0])))
			return {1'b1, {VAL_W{1'b0}}};
		return s[VAL_W:0];
	endfunction

	function automatic logic signed [VAL_W-1:0] sat(input logic signed [SUM_W-1:0] v);
		if ((&v[SUM_W-1:VAL_W-1]) || !(|v[SUM_W-1:VAL_W-1]))
			return v[VAL_W-1:0];
		if (v[SUM_W-1])
			return {1'b1, {(VAL_W-1){1'b0}}};
		return {1'b0, {(VAL_W-1){1'b1}}};
	endfunction

	function automatic logic [VAL_W-1:0] absv(input logic signed [VAL_W-1:0] v);
		return v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
	endfunction

endpackage

/* sv/multi_fractal_escape_time_engine_unit.sv */
// top level of the multi-fractal escape-time engine: stream ports,
// configuration registers and output register; depends on mfe_pkg and mfe_core
//
// Usage: each beat on the s_axis channel carries one complex point in Q4.28.
// The block iterates the selected map (mandelbrot, julia, burning ship,
// manowar, phoenix) until |z|^2 reaches radius^2 or the iteration limit is hit,
// then sends one m_axis beat with the count, the escaped flag and the final
// |z|^2 in Q8.32. One shared 40x20 multiply-accumulate unit forms x^2, y^2 and
// |x||y| in two passes each, so one map step runs through the states SQX0, SQX1,
// SQY0, SQY1, TEST, CR0, CR1 and UPD in turn; the last escape test ends in FIN.
// s_axis_tready is high only while no point is at work; a point
// is taken as soon as the previous result has moved to the output register.
// Configuration writes on the cfg channel are always taken (cfg_ready high) and
// should only be issued while no point is at work.
// Reset clears the sequencer and the output valid and loads the register
// defaults: mandelbrot, limit 256, radius 2, constant zero.
// When m_axis_tready is low the result holds in the output register; the next
// point may still run and then waits for the output register to free up.
module multi_fractal_escape_time_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // point_re, point_im
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // iteration_count, escaped, final_magnitude_sq
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [mfe_pkg::IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data
);
	import mfe_pkg::*;

	cfg_t        cfg_q;
	res_t        res;
	logic        res_valid, res_ready, core_idle, start;
	logic        m_valid_q;
	logic [63:0] m_data_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode   <= MODE_MANDEL;
			cfg_q.limit  <= CNT_W'(256);
			cfg_q.radius <= RAD_W'(2);
			cfg_q.cre    <= '0;
			cfg_q.cim    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODE:   cfg_q.mode   <= cfg_data[MODE_W-1:0];
				REG_LIMIT:  cfg_q.limit  <= cfg_data[CNT_W-1:0];
				REG_RADIUS: cfg_q.radius <= cfg_data[RAD_W-1:0];
				REG_CRE:    cfg_q.cre    <= cfg_data;
				REG_CIM:    cfg_q.cim    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_axis_tready = core_idle;
	assign start         = s_axis_tvalid && core_idle;
	assign res_ready     = !m_valid_q || m_axis_tready;

	mfe_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.start     (start),
		.point_re  (s_axis_tdata[31:0]),
		.point_im  (s_axis_tdata[63:32]),
		.idle      (core_idle),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid)
			m_data_q <= 64'({res.mag, res.escaped, res.count});
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

/* sv/mfe_mul.sv */
// shared multiply-accumulate unit: full unsigned product in two half-width passes
// depends on mfe_pkg
module mfe_mul (
	input  logic                         clk,
	input  mfe_pkg::mul_ctl_t            ctl,
	input  logic [mfe_pkg::VAL_W-1:0]    op_a,
	input  logic [mfe_pkg::VAL_W-1:0]    op_b,
	output logic [mfe_pkg::PROD_W-1:0]   acc
);
	import mfe_pkg::*;

	logic [HALF_W-1:0]        b_sel;
	logic [VAL_W+HALF_W-1:0]  pp;
	logic [PROD_W-1:0]        acc_q;

	assign b_sel = ctl.hi ? op_b[VAL_W-1:HALF_W] : op_b[HALF_W-1:0];
	assign pp    = op_a * b_sel;
	assign acc   = acc_q;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			if (ctl.hi)
				acc_q <= acc_q + (PROD_W'(pp) << HALF_W);
			else
				acc_q <= PROD_W'(pp);
		end
	end

endmodule

/* sv/mfe_core.sv */
// iteration sequencer and datapath of the escape-time engine
// depends on mfe_pkg and mfe_mul
module mfe_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mfe_pkg::cfg_t              cfg,
	input  logic                       start,
	input  logic signed [mfe_pkg::PT_W-1:0] point_re,
	input  logic signed [mfe_pkg::PT_W-1:0] point_im,
	output logic                       idle,
	output logic                       res_valid,
	input  logic                       res_ready,
	output mfe_pkg::res_t              res
);
	import mfe_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SQX0 = 4'd1;
	localparam logic [3:0] ST_SQX1 = 4'd2;
	localparam logic [3:0] ST_SQY0 = 4'd3;
	localparam logic [3:0] ST_SQY1 = 4'd4;
	localparam logic [3:0] ST_TEST = 4'd5;
	localparam logic [3:0] ST_CR0  = 4'd6;
	localparam logic [3:0] ST_CR1  = 4'd7;
	localparam logic [3:0] ST_UPD  = 4'd8;
	localparam logic [3:0] ST_FIN  = 4'd9;

	logic [3:0]               st_q;
	logic [CNT_W-1:0]         n_q;
	logic [MODE_W-1:0]        mode_q;
	logic signed [VAL_W-1:0]  x_q, y_q, px_q, py_q, pr_q, pi_q;
	logic [VAL_W-1:0]         sqx_q, sqy_q;
	res_t                     res_q;

	mul_ctl_t                 mctl;
	logic [VAL_W-1:0]         op_a, op_b, ax, ay;
	logic [PROD_W-1:0]        acc;

	logic [MODE_W-1:0]        mode_n;
	logic signed [VAL_W-1:0]  pr_n, pi_n, cr, ci;
	logic [VAL_W-1:0]         sq_now, mag;
	logic [VAL_W:0]           mag_sum, cm;
	logic [VAL_W-1:0]         esc2;
	logic                     go;
	logic signed [SUM_W-1:0]  d_w, cm_w, cs_w, nx, ny;

	assign ax = absv(x_q);
	assign ay = absv(y_q);

	always_comb begin
		mctl.en = (st_q == ST_SQX0) || (st_q == ST_SQX1) || (st_q == ST_SQY0) ||
			(st_q == ST_SQY1) || (st_q == ST_CR0) || (st_q == ST_CR1);
		mctl.hi = (st_q == ST_SQX1) || (st_q == ST_SQY1) || (st_q == ST_CR1);
		op_a = ax;
		op_b = ax;
		if ((st_q == ST_SQY0) || (st_q == ST_SQY1)) begin
			op_a = ay;
			op_b = ay;
		end else if ((st_q == ST_CR0) || (st_q == ST_CR1)) begin
			op_b = ay;
		end
	end

	mfe_mul u_mul (
		.clk  (clk),
		.ctl  (mctl),
		.op_a (op_a),
		.op_b (op_b),
		.acc  (acc)
	);

	assign mode_n = (cfg.mode > MODE_PHOENIX) ? MODE_MANDEL : cfg.mode;
	assign pr_n   = to_fix(point_re);
	assign pi_n   = to_fix(point_im);
	assign cr     = to_fix(cfg.cre);
	assign ci     = to_fix(cfg.cim);

	// escape test on the squares just formed
	assign sq_now  = sq_cap(acc);
	assign mag_sum = {1'b0, sqx_q} + {1'b0, sq_now};
	assign mag     = mag_sum[VAL_W] ? '1 : mag_sum[VAL_W-1:0];
	assign esc2    = VAL_W'({6'(cfg.radius * cfg.radius), {FRAC_BITS{1'b0}}});
	assign go      = (mag < esc2) && (n_q < cfg.limit);

	// map update
	assign cm   = cross_cap(acc);
	assign cm_w = SUM_W'(cm);
	assign cs_w = (x_q[VAL_W-1] ^ y_q[VAL_W-1]) ? -cm_w : cm_w;
	assign d_w  = SUM_W'(sqx_q) - SUM_W'(sqy_q);

	always_comb begin
		unique case (mode_q)
			MODE_JULIA: begin
				nx = d_w + SUM_W'(cr);
				ny = (cs_w <<< 1) + SUM_W'(ci);
			end
			MODE_SHIP: begin
				nx = d_w + SUM_W'(pr_q);
				ny = (cm_w <<< 1) + SUM_W'(pi_q);
			end
			MODE_MANOWAR: begin
				nx = d_w + SUM_W'(px_q) + SUM_W'(pr_q);
				ny = (cs_w <<< 1) + SUM_W'(py_q) + SUM_W'(pi_q);
			end
			MODE_PHOENIX: begin
				nx = d_w + SUM_W'(PHOENIX_P) - SUM_W'(px_q >>> 1);
				ny = (cs_w <<< 1) - SUM_W'(py_q >>> 1);
			end
			default: begin
				nx = d_w + SUM_W'(pr_q);
				ny = (cs_w <<< 1) + SUM_W'(pi_q);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			n_q  <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (start) begin
						st_q <= ST_SQX0;
						n_q  <= '0;
					end
				end
				ST_SQX0: st_q <= ST_SQX1;
				ST_SQX1: st_q <= ST_SQY0;
				ST_SQY0: st_q <= ST_SQY1;
				ST_SQY1: st_q <= ST_TEST;
				ST_TEST: st_q <= go ? ST_CR0 : ST_FIN;
				ST_CR0:  st_q <= ST_CR1;
				ST_CR1:  st_q <= ST_UPD;
				ST_UPD: begin
					st_q <= ST_SQX0;
					n_q  <= n_q + 1'b1;
				end
				ST_FIN: begin
					if (res_ready)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((st_q == ST_IDLE) && start) begin
			mode_q <= mode_n;
			pr_q   <= pr_n;
			pi_q   <= pi_n;
			if (mode_n == MODE_JULIA) begin
				x_q  <= pr_n;
				y_q  <= pi_n;
				px_q <= '0;
				py_q <= '0;
			end else if (mode_n == MODE_MANOWAR) begin
				x_q  <= pr_n;
				y_q  <= pi_n;
				px_q <= pr_n;
				py_q <= pi_n;
			end else if (mode_n == MODE_PHOENIX) begin
				x_q  <= -pi_n;
				y_q  <= pr_n;
				px_q <= cr;
				py_q <= ci;
			end else begin
				x_q  <= '0;
				y_q  <= '0;
				px_q <= '0;
				py_q <= '0;
			end
		end
		if (st_q == ST_SQY0)
			sqx_q <= sq_now;
		if (st_q == ST_TEST) begin
			sqy_q         <= sq_now;
			res_q.count   <= n_q;
			res_q.escaped <= n_q < cfg.limit;
			res_q.mag     <= mag;
		end
		if (st_q == ST_UPD) begin
			px_q <= x_q;
			py_q <= y_q;
			x_q  <= sat(nx);
			y_q  <= sat(ny);
		end
	end

	assign idle      = (st_q == ST_IDLE);
	assign res_valid = (st_q == ST_FIN);
	assign res       = res_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (st_q == ST_IDLE))
		else $error("start outside idle");

	a_upd_loops: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_UPD) |=> ((st_q == ST_SQX0) && (n_q == $past(n_q) + 1'b1)))
		else $error("update did not advance count and loop");

	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q == ST_FIN) && !res_ready) |=> ((st_q == ST_FIN) && $stable(res_q)))
		else $error("result dropped while stalled");

	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q != ST_UPD) && (st_q != ST_IDLE)) |=> $stable(n_q))
		else $error("count changed outside update");

endmodule

/* bench/tb_multi_fractal_escape_time_engine_unit.sv */
// self-checking bench for multi_fractal_escape_time_engine_unit: a directed set of
// points, then random points under many register settings, checked against an in-bench model
// depends on mfe_pkg and the engine top level
`timescale 1ns / 1ps

module tb_multi_fractal_escape_time_engine_unit;
	import mfe_pkg::*;

	localparam int ONE = 1 << 28;                 // 1.0 in Q4.28
	localparam int SPAN = 671088640;              // 2.5 in Q4.28
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_PHASES = 16;
	localparam int POINTS_PER_PHASE = 56;

	localparam logic [MODE_W-1:0] MODE_RSV5 = 3'd5;
	localparam logic [MODE_W-1:0] MODE_RSV6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_RSV7 = 3'd7;
	localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;

	localparam longint VAL_MAX = 64'h7F_FFFF_FFFF;
	localparam longint VAL_MIN = -VAL_MAX - 1;
	localparam longint MAG_CAP = 64'hFF_FFFF_FFFF;
	localparam longint CROSS_CAP = 64'h100_0000_0000;
	localparam longint PHX_FIX = (64'd56667 * (64'd1 << 32) + 64'd50000) / 64'd100000;

	typedef struct packed {
		logic [15:0] count;
		logic        escaped;
		logic [39:0] mag;
	} escape_result_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [63:0]       s_axis_tdata = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [63:0]       m_axis_tdata;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [31:0]       cfg_data = '0;

	// shadow of the engine registers
	logic [MODE_W-1:0]  mode_q;
	logic [15:0]        limit_q;
	logic [RAD_W-1:0]   radius_q;
	logic signed [31:0] cre_q;
	logic signed [31:0] cim_q;

	// iteration state left by the last point
	longint       last_re, last_im, last_prev_re, last_prev_im;
	logic [15:0]  last_steps;

	logic [63:0]    pending_points[$];
	escape_result_t expected_escapes[$];

	int     points_queued = 0;
	int     results_checked = 0;
	int     escaped_seen = 0;
	int     settings_count = 0;
	int     errors = 0;
	int     src_gap = 0;
	int     sink_stall = 0;
	bit     src_idle = 1'b1;
	bit     sink_idle = 1'b1;
	longint cycle_count = 0;
	longint cycle_budget = 0;

	multi_fractal_escape_time_engine_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// a*b >> 32 for non-negative a and b (callers pass magnitudes), capped
	function automatic longint fix_mul(input longint a, input longint b, input longint cap);
		logic [127:0] p;
		p = a * b;
		p = p >> 32;
		return (p > cap) ? cap : longint'(p[63:0]);
	endfunction

	function automatic longint fix_sq(input longint x);
		longint a;
		a = (x < 0) ? -x : x;
		return fix_mul(a, a, MAG_CAP);
	endfunction

	function automatic longint fix_cross(input longint x, input longint y);
		longint m;
		m = fix_mul((x < 0) ? -x : x, (y < 0) ? -y : y, CROSS_CAP);
		return ((x < 0) != (y < 0)) ? -m : m;
	endfunction

	function automatic longint clamp_val(input longint v);
		if (v > VAL_MAX)
			return VAL_MAX;
		if (v < VAL_MIN)
			return VAL_MIN;
		return v;
	endfunction

	function automatic longint zmag(input longint x, input longint y);
		longint s;
		s = fix_sq(x) + fix_sq(y);
		return (s > MAG_CAP) ? MAG_CAP : s;
	endfunction

	function automatic escape_result_t escape_time(input logic signed [31:0] re,
			input logic signed [31:0] im);
		escape_result_t r;
		longint pt_re, pt_im, k_re, k_im, x, y, px, py, nx, ny, d, c, esc2, mag;
		logic [MODE_W-1:0] m;
		logic [5:0] radius_sq;
		int unsigned n;
		pt_re = longint'(re) * 16;
		pt_im = longint'(im) * 16;
		k_re = longint'(cre_q) * 16;
		k_im = longint'(cim_q) * 16;
		m = (mode_q > MODE_PHOENIX) ? MODE_MANDEL : mode_q;
		radius_sq = radius_q * radius_q;
		esc2 = longint'(radius_sq) <<< 32;
		x = 0;
		y = 0;
		px = 0;
		py = 0;
		n = 0;
		case (m)
			MODE_JULIA: begin
				x = pt_re;
				y = pt_im;
			end
			MODE_MANOWAR: begin
				x = pt_re;
				y = pt_im;
				px = pt_re;
				py = pt_im;
			end
			MODE_PHOENIX: begin
				x = clamp_val(-pt_im);
				y = pt_re;
				px = k_re;
				py = k_im;
			end
			default: ;
		endcase
		mag = zmag(x, y);
		while (mag < esc2 && n < limit_q) begin
			d = fix_sq(x) - fix_sq(y);
			case (m)
				MODE_JULIA: begin
					nx = d + k_re;
					ny = 2 * fix_cross(x, y) + k_im;
				end
				MODE_SHIP: begin
					c = fix_cross(x, y);
					nx = d + pt_re;
					ny = 2 * ((c < 0) ? -c : c) + pt_im;
				end
				MODE_MANOWAR: begin
					nx = d + px + pt_re;
					ny = 2 * fix_cross(x, y) + py + pt_im;
				end
				MODE_PHOENIX: begin
					nx = d + PHX_FIX - (px >>> 1);
					ny = 2 * fix_cross(x, y) - (py >>> 1);
				end
				default: begin
					nx = d + pt_re;
					ny = 2 * fix_cross(x, y) + pt_im;
				end
			endcase
			px = x;
			py = y;
			x = clamp_val(nx);
			y = clamp_val(ny);
			n++;
			mag = zmag(x, y);
		end
		last_re = x;
		last_im = y;
		last_prev_re = px;
		last_prev_im = py;
		last_steps = n[15:0];
		cycle_budget += 8 * longint'(n) + 40;
		r.count = n[15:0];
		r.escaped = (n < limit_q);
		r.mag = mag[39:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		errors++;
		$display("mismatch on %s at result %0d: got 0x%0h, expected 0x%0h",
			what, results_checked, got, want);
	endtask

	// point driver
	always @(posedge clk or negedge arst_n) begin : point_driver
		escape_result_t r;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			src_gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				r = escape_time(s_axis_tdata[31:0], s_axis_tdata[63:32]);
				expected_escapes.push_back(r);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_gap != 0) begin
					src_gap <= src_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pending_points.size() != 0) begin
					s_axis_tdata <= pending_points.pop_front();
					s_axis_tvalid <= 1'b1;
					src_gap <= src_idle ? $urandom_range(0, 5) : 0;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin : result_monitor
		escape_result_t want;
		int hold;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_stall <= 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			if (expected_escapes.size() == 0) begin
				report_mismatch("unexpected result beat", m_axis_tdata, '0);
			end else begin
				want = expected_escapes.pop_front();
				if (m_axis_tdata[15:0] != want.count)
					report_mismatch("iteration_count", m_axis_tdata[15:0], want.count);
				if (m_axis_tdata[16] != want.escaped)
					report_mismatch("escaped", m_axis_tdata[16], want.escaped);
				if (m_axis_tdata[56:17] != want.mag)
					report_mismatch("final_magnitude_sq", m_axis_tdata[56:17], want.mag);
				if (want.escaped)
					escaped_seen++;
				results_checked++;
			end
			hold = sink_idle ? $urandom_range(0, 5) : 0;
			sink_stall <= hold;
			m_axis_tready <= (hold == 0);
		end else if (sink_stall != 0) begin
			sink_stall <= sink_stall - 1;
			m_axis_tready <= (sink_stall == 1);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// register shadow
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_MANDEL;
			limit_q <= 16'd256;
			radius_q <= 3'd2;
			cre_q <= '0;
			cim_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE:   mode_q <= cfg_data[MODE_W-1:0];
				REG_LIMIT:  limit_q <= cfg_data[15:0];
				REG_RADIUS: radius_q <= cfg_data[RAD_W-1:0];
				REG_CRE:    cre_q <= cfg_data;
				REG_CIM:    cim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 4 * cycle_budget + 100000) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("status: fail");
			$finish;
		end
	end

	task automatic queue_point(input logic [31:0] re, input logic [31:0] im);
		pending_points.push_back({im, re});
		points_queued++;
	endtask

	task automatic settle();
		while (results_checked != points_queued)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_setting(input logic [MODE_W-1:0] mode, input logic [15:0] lim,
			input logic [RAD_W-1:0] rad, input logic [31:0] cre, input logic [31:0] cim);
		settle();
		write_reg(REG_MODE, 32'(mode));
		write_reg(REG_LIMIT, 32'(lim));
		write_reg(REG_RADIUS, 32'(rad));
		write_reg(REG_CRE, cre);
		write_reg(REG_CIM, cim);
		settings_count++;
	endtask

	function automatic logic [31:0] pick_coord();
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return 32'($urandom_range(0, 2 * SPAN) - SPAN);
	endfunction

	initial begin : stimulus
		logic [MODE_W-1:0] mode;
		logic [15:0]       lim;
		logic [RAD_W-1:0]  rad;
		int                pick;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: mandelbrot, limit 256, radius 2
		queue_point(0, 0);
		queue_point(-2 * ONE, 0);
		queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		queue_point(32'h8000_0000, 32'h8000_0000);
		queue_point(32'h8000_0000, 32'h7FFF_FFFF);
		queue_point(ONE / 4, 0);

		apply_setting(MODE_JULIA, 64, 2, -3 * ONE / 4, ONE / 8);
		queue_point(0, 0);
		queue_point(32'h7FFF_FFFF, 32'h8000_0000);
		apply_setting(MODE_SHIP, 64, 2, 0, 0);
		queue_point(-7 * ONE / 4, -ONE / 32);
		queue_point(ONE / 2, ONE / 2);
		apply_setting(MODE_MANOWAR, 64, 2, 0, 0);
		queue_point(ONE / 10, ONE / 10);
		queue_point(-ONE, ONE / 5);
		apply_setting(MODE_PHOENIX, 64, 2, -ONE / 2, ONE / 16);
		queue_point(3 * ONE / 10, ONE / 10);
		queue_point(0, 0);

		// no step at all when the limit is zero
		apply_setting(MODE_RSV7, 0, 2, 0, 0);
		queue_point(ONE / 2, ONE / 2);
		apply_setting(MODE_MANOWAR, 0, 2, 0, 0);
		queue_point(ONE, ONE);
		// unused mode with a single step, then a zero radius
		apply_setting(MODE_RSV5, 1, 2, 0, 0);
		queue_point(ONE / 10, ONE / 10);
		apply_setting(MODE_RSV6, 10, 0, 0, 0);
		queue_point(0, 0);
		// radius above four, then a write to an unused register index
		apply_setting(MODE_MANDEL, 100, 7, 0, 0);
		write_reg(REG_SPARE, $urandom);
		queue_point(ONE, ONE);
		queue_point(-2 * ONE, 0);
		// full iteration limit
		apply_setting(MODE_MANDEL, 16'hFFFF, 4, 32'h7FFF_FFFF, 32'h8000_0000);
		queue_point(0, 0);
		queue_point(32'h7FFF_FFFF, 0);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			mode = MODE_W'(ph % 8);
			pick = $urandom_range(0, 9);
			lim = (pick == 0) ? 16'($urandom_range(0, 1)) : 16'($urandom_range(2, 40));
			pick = $urandom_range(0, 11);
			if (pick < 8)
				rad = RAD_W'($urandom_range(1, 4));
			else if (pick == 8)
				rad = '0;
			else
				rad = RAD_W'($urandom_range(5, 7));
			apply_setting(mode, lim, rad, $signed(pick_coord()) >>> 1,
				$signed(pick_coord()) >>> 1);
			src_idle = ($urandom_range(0, 3) != 0);
			sink_idle = ($urandom_range(0, 3) != 0);
			repeat (POINTS_PER_PHASE) queue_point(pick_coord(), pick_coord());
		end

		settle();
		if (expected_escapes.size() != 0)
			report_mismatch("leftover expected results", expected_escapes.size(), 0);
		$display("ran %0d points under %0d register settings across all maps and unused modes",
			points_queued, settings_count);
		$display("%0d points escaped, %0d reached the limit, %0d mismatches",
			escaped_seen, results_checked - escaped_seen, errors);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
